### hw/rtl/kat_pkg.sv
// ----------------------------------------------------------------------------
// kat_pkg
// Shared types and constants for the keyed accumulate table.
// ----------------------------------------------------------------------------
package kat_pkg;

   localparam int ACTION_W      = 2;
   localparam int GROUP_W       = 8;
   localparam int TARGET_W      = 32;
   localparam int AMOUNT_W      = 32;
   localparam int FLAGS_W       = 8;
   localparam int ENTRY_COUNT_W = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_GET   = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_READ_LAST,
      ST_MOVE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [GROUP_W-1:0]  group;
      logic [TARGET_W-1:0] target;
      logic [AMOUNT_W-1:0] amount;
      logic [FLAGS_W-1:0]  flags;
   } record_type;

endpackage

### hw/rtl/kat_req_if.sv
// ----------------------------------------------------------------------------
// kat_req_if
// Request channel: one operation word per handshake.
// ----------------------------------------------------------------------------
interface kat_req_if
   import kat_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [GROUP_W-1:0]  group_id;
   logic [TARGET_W-1:0] target_handle;
   logic [AMOUNT_W-1:0] add_amount;
   logic [FLAGS_W-1:0]  add_flags;

   modport source (output valid, action, group_id, target_handle, add_amount, add_flags,
                   input ready);
   modport sink   (input valid, action, group_id, target_handle, add_amount, add_flags,
                   output ready);
endinterface

### hw/rtl/kat_rsp_if.sv
// ----------------------------------------------------------------------------
// kat_rsp_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface kat_rsp_if
   import kat_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [AMOUNT_W-1:0]      amount_out;
   logic                     hit;
   logic                     dropped;
   logic [ENTRY_COUNT_W-1:0] entry_count;

   modport source (output valid, amount_out, hit, dropped, entry_count, input ready);
   modport sink   (input valid, amount_out, hit, dropped, entry_count, output ready);
endinterface

### hw/rtl/keyed_accumulate_table_core.sv
// ----------------------------------------------------------------------------
// keyed_accumulate_table_core
// Associative table of keyed amount records with a linear search.
//
// req_ch carries one operation word (add, look up, clear) keyed by group id
// and target handle; rsp_ch returns exactly one result word per request.
// Records live in a single-port-read memory that is scanned one record per
// cycle. req_ch.ready is high only while no item is in work, so the block
// takes one item at a time.
// A result sits in an output register; the next request is taken while it
// waits, but that request finishes only once the receiver has taken it.
// Reset (synchronous) empties the table and drops any pending result; the
// record memory itself is not cleared.
// ----------------------------------------------------------------------------
module keyed_accumulate_table_core
   import kat_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic     clock,
   input  logic     reset,
   kat_req_if.sink  req_ch,
   kat_rsp_if.source rsp_ch
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

   record_type rec_mem [MAX_ENTRIES];
   record_type rdata_ff;

   state_type  state_ff, state_in;
   action_type act_ff, act_in;
   logic [GROUP_W-1:0]  grp_ff, grp_in;
   logic [TARGET_W-1:0] tgt_ff, tgt_in;
   logic [AMOUNT_W-1:0] amt_ff, amt_in;
   logic [FLAGS_W-1:0]  flg_ff, flg_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]       cmp_idx_ff, cmp_idx_in;

   logic [AMOUNT_W-1:0] res_amount_ff, res_amount_in;
   logic                res_hit_ff, res_hit_in;
   logic                res_drop_ff, res_drop_in;

   logic                     rsp_vld_ff, rsp_vld_in;
   logic [AMOUNT_W-1:0]      rsp_amount_ff, rsp_amount_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic                     rsp_drop_ff, rsp_drop_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   record_type    wr_data;

   logic                found, issue, full, out_free, act_known;
   logic [AMOUNT_W-1:0] sum;
   logic [CW-1:0]       last_cnt;

   assign found     = cmp_vld_ff && (rdata_ff.group == grp_ff) && (rdata_ff.target == tgt_ff);
   assign issue     = scan_ff < count_ff;
   assign full      = count_ff >= MAX_CNT;
   assign sum       = rdata_ff.amount + amt_ff;
   assign last_cnt  = count_ff - 1'b1;
   assign out_free  = !rsp_vld_ff || rsp_ch.ready;
   assign act_known = (req_ch.action == ACT_ADD) || (req_ch.action == ACT_GET) ||
                      (req_ch.action == ACT_CLEAR);

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.amount_out  = rsp_amount_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.dropped     = rsp_drop_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = act_known ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (found) begin
               unique case (act_ff)
                  ACT_ADD:   state_in = ST_UPDATE;
                  ACT_CLEAR: state_in = ST_READ_LAST;
                  default:   state_in = ST_DONE;
               endcase
            end else if (!issue) begin
               state_in = ST_DONE;
            end
         end
         ST_UPDATE:    state_in = ST_DONE;
         ST_READ_LAST: state_in = ST_MOVE;
         ST_MOVE:      state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      act_in        = act_ff;
      grp_in        = grp_ff;
      tgt_in        = tgt_ff;
      amt_in        = amt_ff;
      flg_in        = flg_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      res_amount_in = res_amount_ff;
      res_hit_in    = res_hit_ff;
      res_drop_in   = res_drop_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_amount_in = rsp_amount_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = cmp_idx_ff;
      wr_data       = rdata_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               act_in        = action_type'(req_ch.action);
               grp_in        = req_ch.group_id;
               tgt_in        = req_ch.target_handle;
               amt_in        = req_ch.add_amount;
               flg_in        = req_ch.add_flags;
               scan_in       = '0;
               cmp_vld_in    = 1'b0;
               res_amount_in = '0;
               res_hit_in    = 1'b0;
               res_drop_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b0;
            if (found) begin
               res_hit_in = 1'b1;
               if (act_ff == ACT_GET) begin
                  res_amount_in = rdata_ff.amount;
               end
            end else if (issue) begin
               rd_en      = 1'b1;
               rd_addr    = scan_ff[AW-1:0];
               cmp_idx_in = scan_ff[AW-1:0];
               cmp_vld_in = 1'b1;
               scan_in    = CW'(scan_ff + 1'b1);
            end else if (act_ff == ACT_ADD) begin
               // miss on add: append or drop
               if (full) begin
                  res_drop_in = 1'b1;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = count_ff[AW-1:0];
                  wr_data       = '{group: grp_ff, target: tgt_ff, amount: amt_ff,
                                    flags: flg_ff};
                  count_in      = CW'(count_ff + 1'b1);
                  res_amount_in = amt_ff;
               end
            end
         end
         ST_UPDATE: begin
            wr_en         = 1'b1;
            wr_addr       = cmp_idx_ff;
            wr_data       = '{group: rdata_ff.group, target: rdata_ff.target, amount: sum,
                              flags: rdata_ff.flags | flg_ff};
            res_amount_in = sum;
         end
         ST_READ_LAST: begin
            rd_en   = 1'b1;
            rd_addr = last_cnt[AW-1:0];
         end
         ST_MOVE: begin
            // last record fills the freed slot
            wr_en    = 1'b1;
            wr_addr  = cmp_idx_ff;
            wr_data  = rdata_ff;
            count_in = last_cnt;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in    = 1'b1;
               rsp_amount_in = res_amount_ff;
               rsp_hit_in    = res_hit_ff;
               rsp_drop_in   = res_drop_ff;
               rsp_count_in  = ENTRY_COUNT_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= rec_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      grp_ff        <= grp_in;
      tgt_ff        <= tgt_in;
      amt_ff        <= amt_in;
      flg_ff        <= flg_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_amount_ff <= res_amount_in;
      res_hit_ff    <= res_hit_in;
      res_drop_ff   <= res_drop_in;
      rsp_amount_ff <= rsp_amount_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyed_accumulate_table_core.
//
// A directed run covers the empty table, the unused action code, key and
// amount extremes, wraparound, and clears of first and last records. Random
// traffic then cycles between growth and drain, so the table fills up and
// drops adds. A local table model predicts every result word.
// Idle and stall patterns change over the run, and one long receiver
// hold-off backs up the request channel.
// ----------------------------------------------------------------------------
module testbench;
   import kat_pkg::*;

   localparam int                  TABLE_DEPTH = 64;
   localparam int                  KEY_POOL    = 96;
   localparam int                  RANDOM_OPS  = 1350;
   localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [GROUP_W-1:0]  group;
      logic [TARGET_W-1:0] target;
      logic [AMOUNT_W-1:0] amount;
      logic [FLAGS_W-1:0]  flags;
   } table_op_type;

   typedef struct packed {
      logic [AMOUNT_W-1:0]      amount;
      logic                     hit;
      logic                     dropped;
      logic [ENTRY_COUNT_W-1:0] count;
   } table_answer_type;

   logic clock;
   logic reset;

   kat_req_if req_bus ();
   kat_rsp_if rsp_bus ();

   keyed_accumulate_table_core #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   table_op_type     op_queue[$];
   table_answer_type pending_answers[$];
   record_type       model_records[TABLE_DEPTH];
   int               model_count;
   int               total_ops;
   int               accepted_ops;
   int               error_count;
   logic             hold_off;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic table_op_type make_op(logic [ACTION_W-1:0] act,
                                            logic [GROUP_W-1:0] grp,
                                            logic [TARGET_W-1:0] tgt,
                                            logic [AMOUNT_W-1:0] amt,
                                            logic [FLAGS_W-1:0] flg);
      table_op_type op;
      op.action = act;
      op.group  = grp;
      op.target = tgt;
      op.amount = amt;
      op.flags  = flg;
      return op;
   endfunction

   // Applies one operation to the local table and returns its result word.
   function automatic table_answer_type predict_table_op(table_op_type op);
      table_answer_type ans;
      int               slot;
      ans  = '0;
      slot = -1;
      for (int i = 0; i < model_count; i++) begin
         if (slot < 0 && model_records[i].group == op.group &&
             model_records[i].target == op.target) begin
            slot = i;
         end
      end
      case (op.action)
         ACT_ADD: begin
            if (slot >= 0) begin
               model_records[slot].amount = model_records[slot].amount + op.amount;
               model_records[slot].flags  = model_records[slot].flags | op.flags;
               ans.amount = model_records[slot].amount;
               ans.hit    = 1'b1;
            end else if (model_count >= TABLE_DEPTH) begin
               ans.dropped = 1'b1;
            end else begin
               model_records[model_count].group  = op.group;
               model_records[model_count].target = op.target;
               model_records[model_count].amount = op.amount;
               model_records[model_count].flags  = op.flags;
               model_count++;
               ans.amount = op.amount;
            end
         end
         ACT_GET: begin
            if (slot >= 0) begin
               ans.amount = model_records[slot].amount;
               ans.hit    = 1'b1;
            end
         end
         ACT_CLEAR: begin
            if (slot >= 0) begin
               model_records[slot] = model_records[model_count-1];
               model_count--;
               ans.hit = 1'b1;
            end
         end
         default: begin
         end
      endcase
      ans.count = model_count[ENTRY_COUNT_W-1:0];
      return ans;
   endfunction

   function automatic int idle_phase();
      if (accepted_ops < total_ops / 3) return 0;
      if (accepted_ops < (2 * total_ops) / 3) return 1;
      return 2;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_answers.push_back(predict_table_op(make_op(req_bus.action,
               req_bus.group_id, req_bus.target_handle, req_bus.add_amount,
               req_bus.add_flags)));
            accepted_ops <= accepted_ops + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (op_queue.size() > 0 &&
                !(idle_phase() == 0 && $urandom_range(0, 99) < 6) &&
                !(idle_phase() == 1 && $urandom_range(0, 99) < 75)) begin
               req_bus.valid         <= 1'b1;
               req_bus.action        <= op_queue[0].action;
               req_bus.group_id      <= op_queue[0].group;
               req_bus.target_handle <= op_queue[0].target;
               req_bus.add_amount    <= op_queue[0].amount;
               req_bus.add_flags     <= op_queue[0].flags;
               void'(op_queue.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      table_answer_type exp_ans;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_answers.size() == 0) begin
               $error("unexpected result word: amount_out %h", rsp_bus.amount_out);
               error_count++;
            end else begin
               exp_ans = pending_answers.pop_front();
               if (rsp_bus.amount_out !== exp_ans.amount) begin
                  $error("amount_out: expected %h, actual %h", exp_ans.amount,
                         rsp_bus.amount_out);
                  error_count++;
               end
               if (rsp_bus.hit !== exp_ans.hit) begin
                  $error("hit: expected %b, actual %b", exp_ans.hit, rsp_bus.hit);
                  error_count++;
               end
               if (rsp_bus.dropped !== exp_ans.dropped) begin
                  $error("dropped: expected %b, actual %b", exp_ans.dropped, rsp_bus.dropped);
                  error_count++;
               end
               if (rsp_bus.entry_count !== exp_ans.count) begin
                  $error("entry_count: expected %0d, actual %0d", exp_ans.count,
                         rsp_bus.entry_count);
                  error_count++;
               end
            end
         end
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (idle_phase() == 0) begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 75);
         end else if (idle_phase() == 1) begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 6);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the block backs up its input
   initial begin
      hold_off = 1'b0;
      wait (accepted_ops >= 1000);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #(12 * 1000000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [GROUP_W-1:0]  pool_group[KEY_POOL];
      logic [TARGET_W-1:0] pool_target[KEY_POOL];
      logic [ACTION_W-1:0] act;
      logic [GROUP_W-1:0]  grp;
      logic [TARGET_W-1:0] tgt;
      logic [AMOUNT_W-1:0] amt;
      int                  pick;
      int                  roll;
      bit                  growing;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.action        = ACT_ADD;
      req_bus.group_id      = '0;
      req_bus.target_handle = '0;
      req_bus.add_amount    = '0;
      req_bus.add_flags     = '0;
      rsp_bus.ready         = 1'b0;
      model_count           = 0;
      accepted_ops          = 0;
      error_count           = 0;

      // directed
      op_queue.push_back(make_op(ACT_GET,   8'h00, 32'h0000_0000, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_CLEAR, 8'h00, 32'h0000_0000, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_NONE,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      op_queue.push_back(make_op(ACT_ADD,   8'h00, 32'h0000_0000, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_ADD,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      op_queue.push_back(make_op(ACT_ADD,   8'hFF, 32'hFFFF_FFFF, 32'h0000_0001, 8'h00));
      op_queue.push_back(make_op(ACT_ADD,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h0F));
      op_queue.push_back(make_op(ACT_GET,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      op_queue.push_back(make_op(ACT_ADD,   8'h00, 32'hFFFF_FFFF, 32'h0000_0005, 8'hA5));
      op_queue.push_back(make_op(ACT_ADD,   8'hFF, 32'h0000_0000, 32'h0000_0007, 8'h5A));
      op_queue.push_back(make_op(ACT_GET,   8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_GET,   8'h01, 32'h0000_0000, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_ADD,   8'h00, 32'h0000_0000, 32'h8000_0000, 8'h80));
      op_queue.push_back(make_op(ACT_CLEAR, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF));
      op_queue.push_back(make_op(ACT_GET,   8'hFF, 32'h0000_0000, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_CLEAR, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_GET,   8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_NONE,  8'h00, 32'h0000_0000, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_CLEAR, 8'hFF, 32'h0000_0000, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_GET,   8'hFF, 32'h0000_0000, 32'h0000_0000, 8'h00));
      op_queue.push_back(make_op(ACT_CLEAR, 8'hFF, 32'h0000_0000, 32'h0000_0000, 8'h00));

      // key pool: some keys share a group, others are fully random
      for (int k = 0; k < KEY_POOL; k++) begin
         pool_group[k]  = (k % 2 == 0) ? GROUP_W'($urandom_range(0, 3)) : GROUP_W'($urandom);
         pool_target[k] = (k % 3 == 0) ? TARGET_W'($urandom_range(0, 15)) : $urandom;
      end

      // growth and drain segments; the pool exceeds the table so it fills
      for (int n = 0; n < RANDOM_OPS; n++) begin
         growing = ((n % 450) < 300);
         pick    = $urandom_range(0, KEY_POOL - 1);
         grp     = pool_group[pick];
         tgt     = pool_target[pick];
         if ($urandom_range(0, 19) == 0) begin
            grp = GROUP_W'($urandom);
            tgt = $urandom;
         end
         case ($urandom_range(0, 7))
            0:       amt = 32'hFFFF_FFFF - $urandom_range(0, 3);
            1:       amt = $urandom_range(0, 3);
            default: amt = $urandom;
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            act = ACT_NONE;
         end else if (growing) begin
            act = (roll < 65) ? ACT_ADD : (roll < 85) ? ACT_GET : ACT_CLEAR;
         end else begin
            act = (roll < 20) ? ACT_ADD : (roll < 40) ? ACT_GET : ACT_CLEAR;
         end
         op_queue.push_back(make_op(act, grp, tgt, amt, FLAGS_W'($urandom)));
      end
      total_ops = op_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted_ops < total_ops || pending_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
